### sv/lba_pkg.sv
// Package for the linked block allocator: sizes, status codes and states.
// Used by the top level.
package lba_pkg;

    localparam int NUM_BLOCKS_DEF  = 1024;
    localparam int NUM_ENTRIES_DEF = 128;
    localparam int MAX_RUN_DEF     = 64;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEN   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BUSY      = 3'd3;
    localparam logic [2:0] ST_NO_SPACE  = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK_RD,
        S_CHK_EV,
        S_CLM_RD,
        S_CLM_EV,
        S_LK_RD,
        S_LK_EV,
        S_WK_RD,
        S_WK_EV,
        S_OUT
    } t_state;

endpackage

### sv/lba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/linked_block_allocator_core.sv
// Top level of the linked block allocator.
// Uses lba_pkg and lba_ram.

// One item is handled at a time. After reset a clearing pass walks every
// block of the used map before the first word is accepted. An allocate
// reads and checks each block from the start block up to the point where
// enough free blocks are found, then reads them again to claim and link
// them, since the used map has a registered read port. A lookup reads and
// compares the table entries in order, then emits the chain one block per
// result word, each result word waiting in an output register until taken.
module linked_block_allocator_core #(
    parameter int NUM_BLOCKS  = lba_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_ENTRIES = lba_pkg::NUM_ENTRIES_DEF,
    parameter int MAX_RUN     = lba_pkg::MAX_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [63:0] i_name_key,
    input  logic [9:0]  i_start_block,
    input  logic [9:0]  i_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_block,
    output logic        o_last
);
    import lba_pkg::*;

    localparam int BW = (NUM_BLOCKS > 1024) ? $clog2(NUM_BLOCKS) + 1 : 11;
    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int LW = $clog2(MAX_RUN + 1);

    t_state r_state, n_state;
    logic [BW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_len, n_len;
    logic [63:0]   r_key, n_key;
    logic [AW-1:0] r_start, n_start;
    logic [CW-1:0] r_ecount, n_ecount;
    logic [CW-1:0] r_eidx, n_eidx;
    logic          r_ovalid, n_ovalid;
    logic [2:0]    r_status, n_status;
    logic [9:0]    r_block, n_block;
    logic          r_last, n_last;

    // Memory ports.
    logic          used_we, used_wd, used_rd;
    logic [AW-1:0] used_wa, used_ra;
    logic          link_we;
    logic [AW-1:0] link_wa, link_wd, link_ra, link_rd;
    logic          ent_we;
    logic [EW-1:0] ent_wa, ent_ra;
    logic [64+AW+LW-1:0] ent_wd, ent_rd;
    logic [63:0]   ent_key_rd;
    logic [AW-1:0] ent_start_rd;
    logic [LW-1:0] ent_len_rd;

    lba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_used (
        .i_clk(i_clk), .i_we(used_we), .i_waddr(used_wa), .i_wdata(used_wd),
        .i_raddr(used_ra), .o_rdata(used_rd));
    lba_ram #(.WIDTH(AW), .DEPTH(NUM_BLOCKS)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(link_ra), .o_rdata(link_rd));
    lba_ram #(.WIDTH(64 + AW + LW), .DEPTH(NUM_ENTRIES)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_wa), .i_wdata(ent_wd),
        .i_raddr(ent_ra), .o_rdata(ent_rd));

    assign ent_key_rd   = ent_rd[64+AW+LW-1 -: 64];
    assign ent_start_rd = ent_rd[AW+LW-1 -: AW];
    assign ent_len_rd   = ent_rd[LW-1:0];

    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_status = r_status;
    assign o_block  = r_block;
    assign o_last   = r_last;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_ecount <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ecount <= n_ecount;
            r_ovalid <= n_ovalid;
        end
        r_prev   <= n_prev;
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_key    <= n_key;
        r_start  <= n_start;
        r_eidx   <= n_eidx;
        r_status <= n_status;
        r_block  <= n_block;
        r_last   <= n_last;
    end

    // Sequencer: next state, memory accesses and result words.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_prev   = r_prev;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_key    = r_key;
        n_start  = r_start;
        n_ecount = r_ecount;
        n_eidx   = r_eidx;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_block  = r_block;
        n_last   = r_last;
        used_we  = 1'b0;
        used_wa  = r_idx[AW-1:0];
        used_wd  = 1'b0;
        used_ra  = r_idx[AW-1:0];
        link_we  = 1'b0;
        link_wa  = r_prev;
        link_wd  = r_idx[AW-1:0];
        link_ra  = r_prev;
        ent_we   = 1'b0;
        ent_wa   = r_ecount[EW-1:0];
        ent_wd   = {r_key, r_start, r_len};
        ent_ra   = r_eidx[EW-1:0];

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            // Clear every block of the used map in turn after reset.
            S_CLEAR: begin
                used_we = 1'b1;
                if (r_idx == BW'(NUM_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
                n_idx = r_idx + 1'b1;
            end
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_key = i_name_key;
                    n_block = '0;
                    n_last = 1'b1;
                    if (i_op) begin
                        n_eidx = '0;
                        if (r_ecount == '0) begin
                            n_status = ST_NOT_FOUND;
                            n_ovalid = 1'b1;
                        end else begin
                            n_state = S_LK_RD;
                        end
                    end else if (i_length == '0 || i_length > 10'(MAX_RUN)) begin
                        n_status = ST_BAD_LEN;
                        n_ovalid = 1'b1;
                    end else if (r_ecount >= CW'(NUM_ENTRIES)) begin
                        n_status = ST_FULL;
                        n_ovalid = 1'b1;
                    end else if (BW'(i_start_block) >= BW'(NUM_BLOCKS)) begin
                        n_status = ST_NO_SPACE;
                        n_ovalid = 1'b1;
                    end else begin
                        n_len   = LW'(i_length);
                        n_start = AW'(i_start_block);
                        n_idx   = BW'(i_start_block);
                        n_cnt   = '0;
                        n_state = S_CHK_RD;
                    end
                end
            end
            // Count free blocks from the start block upward.
            S_CHK_RD: begin
                n_state = S_CHK_EV;
            end
            S_CHK_EV: begin
                if (r_idx == BW'(r_start) && used_rd) begin
                    n_status = ST_BUSY;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else if (!used_rd && r_cnt + 1'b1 == r_len) begin
                    n_idx   = BW'(r_start);
                    n_cnt   = '0;
                    n_state = S_CLM_RD;
                end else if (r_idx == BW'(NUM_BLOCKS - 1)) begin
                    n_status = ST_NO_SPACE;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    if (!used_rd) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CHK_RD;
                end
            end
            // Claim free blocks and link each one to the previous.
            S_CLM_RD: begin
                n_state = S_CLM_EV;
            end
            S_CLM_EV: begin
                n_state = S_CLM_RD;
                n_idx   = r_idx + 1'b1;
                if (!used_rd) begin
                    used_we = 1'b1;
                    used_wd = 1'b1;
                    link_we = (r_cnt != '0);
                    n_prev  = r_idx[AW-1:0];
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == r_len) begin
                        ent_we   = 1'b1;
                        n_ecount = r_ecount + 1'b1;
                        n_status = ST_OK;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            // Search the file table in order.
            S_LK_RD: begin
                n_state = S_LK_EV;
            end
            S_LK_EV: begin
                if (ent_key_rd == r_key) begin
                    n_prev  = ent_start_rd;
                    n_len   = ent_len_rd;
                    n_cnt   = '0;
                    n_state = S_OUT;
                end else if (r_eidx + 1'b1 == r_ecount) begin
                    n_status = ST_NOT_FOUND;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_eidx  = r_eidx + 1'b1;
                    n_state = S_LK_RD;
                end
            end
            // Emit one chain block once the output register is free.
            S_OUT: begin
                if (!r_ovalid) begin
                    n_status = ST_OK;
                    n_block  = 10'(r_prev);
                    n_last   = (r_cnt + 1'b1 == r_len);
                    n_ovalid = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    n_state  = (r_cnt + 1'b1 == r_len) ? S_IDLE : S_WK_RD;
                end
            end
            // Follow the link to the next block.
            S_WK_RD: begin
                n_state = S_WK_EV;
            end
            S_WK_EV: begin
                n_prev  = link_rd;
                n_state = S_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
